// ===== sv/rlx_pkg.sv =====
// Shared constants and types for the RIP-relative LEA cross-reference scanner.
// No dependencies; compiled first.
package rlx_pkg;

    localparam int ADDR_W    = 64;
    localparam int IDX_W     = 2;
    localparam int COUNT_W   = 3;
    localparam int CFG_IDX_W = 3;

    // Number of target address registers in the register map
    localparam int REG_SLOTS            = 4;
    localparam int DEFAULT_TARGET_SLOTS = 4;

    // Instruction encoding
    localparam logic [7:0] PFX_REX_W  = 8'h48;
    localparam logic [7:0] PFX_REX_WR = 8'h4C;
    localparam logic [7:0] OPC_LEA    = 8'h8D;
    localparam logic [7:0] MODRM_MASK = 8'hC7;
    localparam logic [7:0] MODRM_RIP  = 8'h05;

    localparam int LEA_LEN  = 7;
    localparam int WIN_LEN  = LEA_LEN - 1;
    localparam int SKIP_LEN = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCAN_BASE    = 3'd0,
        CFG_TARGET_COUNT = 3'd1,
        CFG_TARGET_0     = 3'd2,
        CFG_TARGET_1     = 3'd3,
        CFG_TARGET_2     = 3'd4,
        CFG_TARGET_3     = 3'd5
    } t_cfg_reg;

endpackage

// ===== sv/rlx_if.sv =====
// Valid/ready channel interfaces: code bytes in, found results out, register writes.
// Depends on rlx_pkg.
interface rlx_byte_if;
    import rlx_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       last_byte;
    modport source (output valid, code_byte, last_byte, input ready);
    modport sink   (input valid, code_byte, last_byte, output ready);
endinterface

interface rlx_result_if;
    import rlx_pkg::*;
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  target_index;
    logic [ADDR_W-1:0] instruction_address;
    logic              all_found;
    modport source (output valid, target_index, instruction_address, all_found, input ready);
    modport sink   (input valid, target_index, instruction_address, all_found, output ready);
endinterface

interface rlx_cfg_if;
    import rlx_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [ADDR_W-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/rip_relative_lea_xref_scanner.sv =====
// RIP-relative LEA cross-reference scanner, top level.
// Depends on rlx_pkg and the channel interfaces in rlx_if.sv.
//
// Usage:
//   i_cfg    : register writes (scan base, target count, four target addresses).
//              Write only while the block is idle; ready is low while a byte
//              sits in the input register.
//   i_byte   : code bytes in address order, last_byte marks the final byte.
//   o_result : one transfer per newly found target (slot, LEA address, all_found).
// Flow: a transferred byte is held in the input register and evaluated from there;
//   its result, if any, is registered in the output register. Throughput: one
//   byte per cycle while o_result.ready does not stall the output register, set
//   by the combinational loop through target add, slot compare and found-mark update.
// Stall: the output register holds while o_result.ready is low; the byte in
//   the input register waits, and i_byte.ready drops until the result leaves.
// Reset (synchronous, active low): configuration registers return to zero, window,
//   position, skip count and found marks clear; both ready outputs are low during reset.
// The last byte also clears window, position, skip count and found marks.
module rip_relative_lea_xref_scanner #(
    parameter int TARGET_SLOTS = rlx_pkg::DEFAULT_TARGET_SLOTS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rlx_cfg_if.sink       i_cfg,
    rlx_byte_if.sink      i_byte,
    rlx_result_if.source  o_result
);
    import rlx_pkg::*;

    // only as many slots as there are address registers can ever be live
    localparam int USED  = (TARGET_SLOTS < REG_SLOTS) ? TARGET_SLOTS : REG_SLOTS;
    localparam int CNT_W = $clog2(USED + 1);

    // configuration
    logic [ADDR_W-1:0]  r_scan_base,    n_scan_base;
    logic [COUNT_W-1:0] r_target_count, n_target_count;
    logic [ADDR_W-1:0]  r_target [REG_SLOTS];
    logic [ADDR_W-1:0]  n_target [REG_SLOTS];

    // scan state
    logic [7:0]         r_win [WIN_LEN];
    logic [7:0]         n_win [WIN_LEN];
    logic [ADDR_W-1:0]  r_pos,       n_pos;
    logic [ADDR_W-1:0]  r_lea_end,   n_lea_end;   // scan_base + pos + 1 = LEA addr + 7
    logic [2:0]         r_skip,      n_skip;
    logic [USED-1:0]    r_found,     n_found;
    logic [CNT_W-1:0]   r_total,     n_total;

    // input register
    logic               r_in_valid,  n_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_last;

    // output register
    logic               r_out_valid, n_out_valid;
    logic [IDX_W-1:0]   r_out_index, n_out_index;
    logic [ADDR_W-1:0]  r_out_addr,  n_out_addr;
    logic               r_out_all,   n_out_all;

    logic               cfg_fire, in_fire, eval_fire;
    logic [CNT_W-1:0]   slot_limit, live_cnt;
    logic [USED-1:0]    slot_live, hit_sel;
    logic [IDX_W-1:0]   hit_idx;
    logic               hit_any, pos_primed, is_lea;
    logic [ADDR_W-1:0]  disp, target;
    logic [CNT_W-1:0]   total_inc;

    assign eval_fire    = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_byte.ready = i_rst_n && (!r_in_valid || eval_fire);
    assign i_cfg.ready  = i_rst_n && !r_in_valid;
    assign in_fire      = i_byte.valid && i_byte.ready;
    assign cfg_fire     = i_cfg.valid && i_cfg.ready;

    assign o_result.valid               = r_out_valid;
    assign o_result.target_index        = r_out_index;
    assign o_result.instruction_address = r_out_addr;
    assign o_result.all_found           = r_out_all;

    // slots in use: below the clamped count and nonzero
    assign slot_limit = (int'(r_target_count) > USED) ? CNT_W'(USED)
                                                      : CNT_W'(r_target_count);
    always_comb begin
        for (int k = 0; k < USED; k++) begin
            slot_live[k] = (k < int'(slot_limit)) && (r_target[k] != '0);
        end
    end
    assign live_cnt = CNT_W'($countones(slot_live));

    // pattern check on window plus the byte now in the input register
    assign pos_primed = (r_pos >= ADDR_W'(WIN_LEN));
    assign is_lea = ((r_win[0] == PFX_REX_W) || (r_win[0] == PFX_REX_WR)) &&
                    (r_win[1] == OPC_LEA) &&
                    ((r_win[2] & MODRM_MASK) == MODRM_RIP);
    assign disp   = {{(ADDR_W-32){r_in_byte[7]}}, r_in_byte, r_win[5], r_win[4], r_win[3]};
    assign target = r_lea_end + disp;

    // first live, unfound slot that matches
    always_comb begin
        hit_sel = '0;
        hit_idx = '0;
        hit_any = 1'b0;
        for (int k = 0; k < USED; k++) begin
            if (!hit_any && slot_live[k] && !r_found[k] && (target == r_target[k])) begin
                hit_sel[k] = 1'b1;
                hit_idx    = IDX_W'(k);
                hit_any    = 1'b1;
            end
        end
    end
    assign total_inc = r_total + CNT_W'(1);

    always_comb begin
        n_scan_base    = r_scan_base;
        n_target_count = r_target_count;
        n_target       = r_target;
        n_win          = r_win;
        n_pos          = r_pos;
        n_lea_end      = r_lea_end;
        n_skip         = r_skip;
        n_found        = r_found;
        n_total        = r_total;
        n_in_valid     = r_in_valid;
        n_out_valid    = r_out_valid && !o_result.ready;
        n_out_index    = r_out_index;
        n_out_addr     = r_out_addr;
        n_out_all      = r_out_all;

        if (in_fire) begin
            n_in_valid = 1'b1;
        end else if (eval_fire) begin
            n_in_valid = 1'b0;
        end

        // register writes never meet an evaluation: cfg ready needs an empty input reg
        if (cfg_fire) begin
            unique case (i_cfg.index)
                CFG_SCAN_BASE: begin
                    n_scan_base = i_cfg.data;
                    n_lea_end   = i_cfg.data + r_pos + ADDR_W'(1);
                end
                CFG_TARGET_COUNT: n_target_count = i_cfg.data[COUNT_W-1:0];
                CFG_TARGET_0:     n_target[0]    = i_cfg.data;
                CFG_TARGET_1:     n_target[1]    = i_cfg.data;
                CFG_TARGET_2:     n_target[2]    = i_cfg.data;
                CFG_TARGET_3:     n_target[3]    = i_cfg.data;
                default: ;
            endcase
        end

        if (eval_fire) begin
            if (pos_primed) begin
                if (r_skip != '0) begin
                    n_skip = r_skip - 3'd1;
                end else if (!r_in_last && (live_cnt != '0) && (r_total < live_cnt)
                             && is_lea) begin
                    if (hit_any) begin
                        n_found     = r_found | hit_sel;
                        n_total     = total_inc;
                        n_out_valid = 1'b1;
                        n_out_index = hit_idx;
                        n_out_addr  = r_lea_end - ADDR_W'(LEA_LEN);
                        n_out_all   = (total_inc >= live_cnt);
                    end
                    n_skip = 3'(SKIP_LEN);
                end
            end

            if (r_in_last) begin
                for (int i = 0; i < WIN_LEN; i++) n_win[i] = '0;
                n_pos     = '0;
                n_lea_end = r_scan_base + ADDR_W'(1);
                n_skip    = '0;
                n_found   = '0;
                n_total   = '0;
            end else begin
                for (int i = 0; i < WIN_LEN - 1; i++) n_win[i] = r_win[i+1];
                n_win[WIN_LEN-1] = r_in_byte;
                n_pos     = r_pos + ADDR_W'(1);
                n_lea_end = r_lea_end + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_base    <= '0;
            r_target_count <= '0;
            for (int k = 0; k < REG_SLOTS; k++) r_target[k] <= '0;
            for (int i = 0; i < WIN_LEN; i++) r_win[i] <= '0;
            r_pos          <= '0;
            r_lea_end      <= ADDR_W'(1);
            r_skip         <= '0;
            r_found        <= '0;
            r_total        <= '0;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_scan_base    <= n_scan_base;
            r_target_count <= n_target_count;
            r_target       <= n_target;
            r_win          <= n_win;
            r_pos          <= n_pos;
            r_lea_end      <= n_lea_end;
            r_skip         <= n_skip;
            r_found        <= n_found;
            r_total        <= n_total;
            r_in_valid     <= n_in_valid;
            r_out_valid    <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_byte <= i_byte.code_byte;
            r_in_last <= i_byte.last_byte;
        end
        r_out_index <= n_out_index;
        r_out_addr  <= n_out_addr;
        r_out_all   <= n_out_all;
    end

endmodule

// ===== sv/rlx_checker.sv =====
// Port-level assertions for the scanner, attached by bind.
// Depends on rlx_pkg and rip_relative_lea_xref_scanner.
module rlx_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [rlx_pkg::IDX_W-1:0] i_out_index,
    input logic [rlx_pkg::ADDR_W-1:0] i_out_addr,
    input logic                      i_out_all
);
    import rlx_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_index)
            && $stable(i_out_addr) && $stable(i_out_all))
        else $error("result changed while stalled");

    // reset empties the output register
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a fresh result must follow an earlier byte transfer
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result without matching byte transfer");

endmodule

bind rip_relative_lea_xref_scanner rlx_checker u_rlx_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_byte.valid),
    .i_in_ready  (i_byte.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_index (o_result.target_index),
    .i_out_addr  (o_result.instruction_address),
    .i_out_all   (o_result.all_found)
);
